FILE: sv/rrd_pkg.sv
// Shared types, constants and calendar helpers for the rapid reset detector.
// Used by rrd_date_conv, rrd_seq_track and rapid_reset_detector; no dependencies.
`timescale 1ns / 1ps

package rrd_pkg;

    localparam int unsigned YEAR_W   = 12;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;

    localparam int unsigned IN_FIELDS_W = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W + SECOND_W;
    localparam int unsigned S_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W   = 8;

    localparam int unsigned WINDOW_W = 16;
    localparam int unsigned TALLY_W  = 8;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned SECS_W   = 32;
    localparam int unsigned DAYS_W   = 16;
    localparam int unsigned SOD_W    = 17;

    localparam logic [YEAR_W-1:0]   EPOCH_YEAR = 12'd2020;
    localparam logic [YEAR_W-1:0]   LAST_YEAR  = 12'd2155;
    // 2100 is the only century year in range, and it is not a leap year.
    localparam logic [YEAR_W-1:0]   CENTURY_YEAR = 12'd2100;
    localparam logic [7:0]          CENTURY_OFFSET = 8'd80;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd10;
    localparam logic [TALLY_W-1:0]  BOOTS_RESET  = 8'd3;

    typedef enum logic [0:0] {
        REG_WINDOW_SECONDS = 1'b0,
        REG_BOOTS_REQUIRED = 1'b1
    } rrd_reg_idx_t;

    // Converted stamp handed from the date converter to the sequence tracker.
    typedef struct packed {
        logic [SECS_W-1:0] secs;
        logic              invalid;
    } rrd_stamp_t;

    // Length of a month; zero for month codes outside 1 to 12.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mo,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        len = '0;
        unique case (mo)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = '0;
        endcase
        return len;
    endfunction

    // Days in a common year before the first of the month.
    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] mo);
        logic [8:0] d;
        d = '0;
        unique case (mo)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

FILE: sv/rrd_date_conv.sv
// Two-stage date converter: stamp check and day count, then seconds since 2020-01-01.
// Depends on rrd_pkg.
`timescale 1ns / 1ps

module rrd_date_conv (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [rrd_pkg::YEAR_W-1:0]   year,
    input  logic [rrd_pkg::MONTH_W-1:0]  month,
    input  logic [rrd_pkg::DAY_W-1:0]    day,
    input  logic [rrd_pkg::HOUR_W-1:0]   hour,
    input  logic [rrd_pkg::MINUTE_W-1:0] minute,
    input  logic [rrd_pkg::SECOND_W-1:0] second,
    output logic                         out_valid,
    input  logic                         out_ready,
    output rrd_pkg::rrd_stamp_t          out_stamp
);

    logic                         v1_reg, v1_next;
    logic                         v2_reg, v2_next;
    logic [rrd_pkg::DAYS_W-1:0]   days_reg, days_next;
    logic [rrd_pkg::SOD_W-1:0]    sod_reg, sod_next;
    logic                         inv1_reg, inv1_next;
    rrd_pkg::rrd_stamp_t          stamp_reg, stamp_next;

    logic                         en1, en2;
    logic                         leap;
    logic [7:0]                   yoff;
    logic [8:0]                   leaps_before;
    logic [rrd_pkg::DAY_W-1:0]    mlen;
    logic                         year_ok, month_ok, day_ok, time_ok;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // Stage one: validate the stamp, count whole days and seconds of the day.
    always_comb begin
        year_ok  = (year >= rrd_pkg::EPOCH_YEAR) && (year <= rrd_pkg::LAST_YEAR);
        leap     = (year[1:0] == 2'b00) && (year != rrd_pkg::CENTURY_YEAR);
        mlen     = rrd_pkg::month_len(month, leap);
        month_ok = (month >= 4'd1) && (month <= 4'd12);
        day_ok   = (day >= 5'd1) && (day <= mlen);
        time_ok  = (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59);
        inv1_next = !(year_ok && month_ok && day_ok && time_ok);

        yoff = 8'(year - rrd_pkg::EPOCH_YEAR);
        // Leap years in [2020, year): one every four from 2020, less 2100 once passed.
        leaps_before = 9'((9'(yoff) + 9'd3) >> 2)
                     - ((yoff > rrd_pkg::CENTURY_OFFSET) ? 9'd1 : 9'd0);
        days_next = 16'(17'(yoff) * 17'd365)
                  + 16'(leaps_before)
                  + 16'(rrd_pkg::days_before_month(month))
                  + ((leap && (month > 4'd2)) ? 16'd1 : 16'd0)
                  + 16'(day - 5'd1);
        sod_next = 17'(17'(hour) * 17'd3600) + 17'(17'(minute) * 17'd60) + 17'(second);

        v1_next = en1 ? in_valid : v1_reg;
        v2_next = en2 ? v1_reg : v2_reg;

        // Stage two: one multiply by the seconds in a day.
        stamp_next.secs    = 32'(days_reg) * 32'd86400 + 32'(sod_reg);
        stamp_next.invalid = inv1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            days_reg <= days_next;
            sod_reg  <= sod_next;
            inv1_reg <= inv1_next;
        end
        if (en2) begin
            stamp_reg <= stamp_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_stamp = stamp_reg;

endmodule

FILE: sv/rrd_seq_track.sv
// Boot sequence tracker: holds the sequence state, decides each boot, registers the result.
// Depends on rrd_pkg.
`timescale 1ns / 1ps

module rrd_seq_track (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [rrd_pkg::WINDOW_W-1:0]  window_seconds,
    input  logic [rrd_pkg::TALLY_W-1:0]   boots_required,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rrd_pkg::rrd_stamp_t           in_stamp,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic                          triggered,
    output logic                          stamp_invalid
);

    logic                          hist_reg, hist_next;
    logic [rrd_pkg::SECS_W-1:0]    first_reg, first_next;
    logic [rrd_pkg::SECS_W-1:0]    last_reg, last_next;
    logic [rrd_pkg::TALLY_W-1:0]   tally_reg, tally_next;
    logic                          res_valid_reg, res_valid_next;
    logic                          trig_reg, trig_next;
    logic                          inv_reg, inv_next;

    logic                          en_out, decide;
    logic                          follows;
    logic [rrd_pkg::SECS_W-1:0]    since_first;
    logic [rrd_pkg::TALLY_W-1:0]   new_tally;
    logic [rrd_pkg::SECS_W-1:0]    new_first;

    assign en_out   = !res_valid_reg || res_ready;
    assign in_ready = en_out;
    assign decide   = in_valid && en_out;

    always_comb begin
        since_first = in_stamp.secs - first_reg;
        follows = hist_reg && (tally_reg != '0) && (tally_reg < boots_required)
                && (in_stamp.secs >= last_reg)
                && (since_first <= 32'(window_seconds));
        new_tally = follows ? tally_reg + 8'd1 : 8'd1;
        new_first = follows ? first_reg : in_stamp.secs;

        trig_next = !in_stamp.invalid && (new_tally >= boots_required);
        inv_next  = in_stamp.invalid;

        hist_next  = hist_reg;
        first_next = first_reg;
        last_next  = last_reg;
        tally_next = tally_reg;
        if (decide && !in_stamp.invalid) begin
            hist_next = 1'b1;
            if (trig_next) begin
                first_next = '0;
                last_next  = '0;
                tally_next = '0;
            end else begin
                first_next = new_first;
                last_next  = in_stamp.secs;
                tally_next = new_tally;
            end
        end
        res_valid_next = en_out ? in_valid : res_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg      <= 1'b0;
            first_reg     <= '0;
            last_reg      <= '0;
            tally_reg     <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            hist_reg      <= hist_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            tally_reg     <= tally_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            trig_reg <= trig_next;
            inv_reg  <= inv_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign triggered     = trig_reg;
    assign stamp_invalid = inv_reg;

    a_invalid_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        decide && in_stamp.invalid |=> $stable(tally_reg) && $stable(first_reg)
                                       && $stable(hist_reg))
        else $error("rejected stamp changed the sequence state");

    a_trigger_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        decide && trig_next |=> (tally_reg == '0) && (first_reg == '0) && hist_reg)
        else $error("sequence not cleared after trigger");

    a_history_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        hist_reg |=> hist_reg)
        else $error("history flag dropped");

    a_result_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(res_valid_reg) |-> !(trig_reg && inv_reg))
        else $error("result flags both trigger and invalid stamp");

endmodule

FILE: sv/rapid_reset_detector.sv
// Top level of the rapid reset detector: configuration registers and stream ports.
// Depends on rrd_pkg, rrd_date_conv and rrd_seq_track.
`timescale 1ns / 1ps

// Channel    Direction  Handshake          Payload
// s_ (boot)  in         s_tvalid/s_tready  s_tdata: year, month, day, hour, minute, second
// m_ (result) out       m_tvalid/m_tready  m_tdata: triggered, stamp_invalid
// cfg        in         cfg_wr_en          cfg_addr selects the register, cfg_wdata the value
//
// Each boot transfer yields exactly one result transfer after passing through a
// check and day-count stage, a seconds stage around one 16 by 17 bit multiply, and
// the result register where the sequence decision is made. A new boot can be taken
// in every cycle while the result side is not stalled; the decision and the state
// update happen in the same cycle, so consecutive boots see each other's effect.
// Stalls on the result side back up stage by stage; s_tready drops only once every
// stage holds a transfer. Reset is synchronous and active low and clears all valid
// flags, the sequence state and the configuration registers to their defaults.

module rapid_reset_detector (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0 up: year[11:0], month[15:12], day[20:16], hour[25:21],
    // minute[31:26], second[37:32], zero padding[39:38].
    input  logic [rrd_pkg::S_TDATA_W-1:0]   s_tdata,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0 up: triggered[0], stamp_invalid[1], zero padding[7:2].
    output logic [rrd_pkg::M_TDATA_W-1:0]   m_tdata,

    input  logic                            cfg_wr_en,
    input  rrd_pkg::rrd_reg_idx_t           cfg_addr,
    input  logic [rrd_pkg::CFG_W-1:0]       cfg_wdata
);

    logic [rrd_pkg::WINDOW_W-1:0] window_reg, window_next;
    logic [rrd_pkg::TALLY_W-1:0]  boots_reg, boots_next;

    logic                         conv_valid, conv_ready;
    rrd_pkg::rrd_stamp_t          conv_stamp;
    logic                         trig, inv;

    // Configuration writes land directly; software must write only while the block is idle, which it does not enforce.
    always_comb begin
        window_next = window_reg;
        boots_next  = boots_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                rrd_pkg::REG_WINDOW_SECONDS: window_next = cfg_wdata;
                rrd_pkg::REG_BOOTS_REQUIRED: boots_next  = cfg_wdata[rrd_pkg::TALLY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= rrd_pkg::WINDOW_RESET;
            boots_reg  <= rrd_pkg::BOOTS_RESET;
        end else begin
            window_reg <= window_next;
            boots_reg  <= boots_next;
        end
    end

    rrd_date_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .year      (s_tdata[11:0]),
        .month     (s_tdata[15:12]),
        .day       (s_tdata[20:16]),
        .hour      (s_tdata[25:21]),
        .minute    (s_tdata[31:26]),
        .second    (s_tdata[37:32]),
        .out_valid (conv_valid),
        .out_ready (conv_ready),
        .out_stamp (conv_stamp)
    );

    rrd_seq_track u_track (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .window_seconds (window_reg),
        .boots_required (boots_reg),
        .in_valid       (conv_valid),
        .in_ready       (conv_ready),
        .in_stamp       (conv_stamp),
        .res_valid      (m_tvalid),
        .res_ready      (m_tready),
        .triggered      (trig),
        .stamp_invalid  (inv)
    );

    assign m_tdata = {6'b0, inv, trig};

endmodule
